>>> src/lfs_pkg.sv
// lfs_pkg: shared types, sizes and constants of the line follow steering block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lfs_pkg;

	// sizes
	localparam int CHANNELS            = 6;
	localparam int SAMPLES_PER_AVERAGE = 5;
	localparam int SAMPLE_BITS         = 12;
	localparam int THR_W               = 12;
	localparam int STOP_W              = 3;
	localparam int HOLD_W              = 16;
	localparam int SPEED_W             = 14;
	localparam int CFG_IDX_W           = 2;
	localparam int CFG_DATA_W          = 16;

	// per-channel sum, threshold limit, round counter and line count widths
	localparam int AVG_LOG = $clog2(SAMPLES_PER_AVERAGE);
	localparam int SUM_W   = SAMPLE_BITS + AVG_LOG;
	localparam int LIM_W   = THR_W + 1 + AVG_LOG;
	localparam int RC_W    = $clog2(SAMPLES_PER_AVERAGE + 1);
	localparam int CNT_W   = $clog2(CHANNELS + 1);

	// register reset values
	localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(20);
	localparam logic [STOP_W-1:0]   STOP_RESET   = STOP_W'(3);
	localparam logic [HOLD_W-1:0]   HOLD_RESET   = HOLD_W'(50);
	localparam logic [CHANNELS-1:0] IGNORE_RESET = CHANNELS'(12);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LINE_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_LINE_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPIN_HOLD_ROUNDS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IGNORED_CHANNELS = 2'd3;

	// channels with a steering role
	localparam int CH_HARD_LEFT  = 0;
	localparam int CH_SOFT_LEFT  = 1;
	localparam int CH_SOFT_RIGHT = 4;
	localparam int CH_HARD_RIGHT = 5;
	localparam int CH_SPIN_STOP  = 4;

	// wheel speeds
	localparam logic signed [SPEED_W-1:0] SPD_ZERO  = 14'sd0;
	localparam logic signed [SPEED_W-1:0] SPD_1000  = 14'sd1000;
	localparam logic signed [SPEED_W-1:0] SPD_2000  = 14'sd2000;
	localparam logic signed [SPEED_W-1:0] SPD_2500  = 14'sd2500;
	localparam logic signed [SPEED_W-1:0] SPD_3000  = 14'sd3000;
	localparam logic signed [SPEED_W-1:0] SPD_3200  = 14'sd3200;
	localparam logic signed [SPEED_W-1:0] SPD_4000  = 14'sd4000;
	localparam logic signed [SPEED_W-1:0] SPD_6000  = 14'sd6000;
	localparam logic signed [SPEED_W-1:0] SPD_SPIN_LEFT  = SPD_3000;
	localparam logic signed [SPEED_W-1:0] SPD_SPIN_RIGHT = -SPD_2000;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_FOLLOW = 2'd1,
		MODE_TURN   = 2'd2,
		MODE_SPIN   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample_ch0;
		logic [SAMPLE_BITS-1:0] sample_ch1;
		logic [SAMPLE_BITS-1:0] sample_ch2;
		logic [SAMPLE_BITS-1:0] sample_ch3;
		logic [SAMPLE_BITS-1:0] sample_ch4;
		logic [SAMPLE_BITS-1:0] sample_ch5;
		logic                   start_command;
	} in_item_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] left_speed;
		logic signed [SPEED_W-1:0] right_speed;
		logic                      speed_update;
		logic [CHANNELS-1:0]       line_mask;
		logic [1:0]                drive_mode;
	} out_item_t;

	// control from the steering stage to every lane
	typedef struct packed {
		logic             add;
		logic             clear;
		logic [LIM_W-1:0] limit;
	} lane_ctl_t;

endpackage

`default_nettype wire

>>> src/lfs_lane.sv
// lfs_lane: one sensor channel, running sum over a round group and line test
// depends on lfs_pkg
`timescale 1ns / 1ps
`default_nettype none

module lfs_lane
	import lfs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire lane_ctl_t              ctl,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	output logic                        hit
);

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_next;

	// sum including this round, tested against the scaled threshold
	assign sum_next = sum_q + SUM_W'(sample);
	assign hit      = LIM_W'(sum_next) >= ctl.limit;

	// accumulate, restart after the evaluating round
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.add) begin
			sum_q <= ctl.clear ? '0 : sum_next;
		end
	end

endmodule

`default_nettype wire

>>> src/lfs_steer.sv
// lfs_steer: merges the lane hits, runs the drive mode machine and picks speeds
// depends on lfs_pkg
`timescale 1ns / 1ps
`default_nettype none

module lfs_steer
	import lfs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic                start,
	input  wire logic [CHANNELS-1:0] hits,
	input  wire logic [CHANNELS-1:0] ignore_mask,
	input  wire logic [STOP_W-1:0]   stop_count,
	input  wire logic [HOLD_W-1:0]   hold_rounds,
	input  wire logic [LIM_W-1:0]    limit,
	output lane_ctl_t                ctl,
	output logic                     produce,
	output out_item_t                result
);

	mode_t             mode_q, mode_d, mode_eff;
	logic [HOLD_W-1:0] hold_q, hold_d;
	logic [RC_W-1:0]   round_q, round_d;
	logic              hold_zero;
	logic              eval;
	logic [CHANNELS-1:0] lines;
	logic [CNT_W-1:0]  line_count;
	logic              stop;

	// start command first, then the hold and round bookkeeping
	assign mode_eff   = (mode_q == MODE_IDLE && start) ? MODE_FOLLOW : mode_q;
	assign hold_zero  = (hold_q == '0);
	assign eval       = (round_q == RC_W'(SAMPLES_PER_AVERAGE - 1));
	assign lines      = hits & ~ignore_mask;
	assign line_count = CNT_W'($countones(lines));
	assign stop       = line_count >= CNT_W'(stop_count);

	assign ctl.add   = accept && hold_zero;
	assign ctl.clear = eval;
	assign ctl.limit = limit;
	assign produce   = ctl.add && eval;

	// next state
	always_comb begin
		mode_d  = mode_q;
		hold_d  = hold_q;
		round_d = round_q;
		if (accept) begin
			mode_d = mode_eff;
			if (!hold_zero) begin
				hold_d = hold_q - HOLD_W'(1);
			end else if (!eval) begin
				round_d = round_q + RC_W'(1);
			end else begin
				round_d = '0;
				unique case (mode_eff)
					MODE_FOLLOW: begin
						if (stop) mode_d = MODE_TURN;
					end
					MODE_TURN: begin
						mode_d = MODE_SPIN;
						hold_d = hold_rounds;
					end
					MODE_SPIN: begin
						if (lines[CH_SPIN_STOP]) mode_d = MODE_IDLE;
					end
					MODE_IDLE: begin
						mode_d = MODE_IDLE;
					end
					default: begin
						mode_d = mode_eff;
					end
				endcase
			end
		end
	end

	// result fields for the evaluating round
	always_comb begin
		result              = '0;
		result.line_mask    = lines;
		result.drive_mode   = mode_d;
		result.speed_update = 1'b1;
		unique case (mode_eff)
			MODE_FOLLOW: begin
				if (stop) begin
					result.left_speed  = SPD_ZERO;
					result.right_speed = SPD_ZERO;
				end else if (lines[CH_HARD_LEFT]) begin
					result.left_speed  = SPD_3000;
					result.right_speed = SPD_3200;
				end else if (lines[CH_SOFT_LEFT]) begin
					result.left_speed  = SPD_3000;
					result.right_speed = SPD_2500;
				end else if (lines[CH_SOFT_RIGHT]) begin
					result.left_speed  = SPD_4000;
					result.right_speed = SPD_2000;
				end else if (lines[CH_HARD_RIGHT]) begin
					result.left_speed  = SPD_6000;
					result.right_speed = SPD_2000;
				end else begin
					result.left_speed  = SPD_3000;
					result.right_speed = SPD_2000;
				end
			end
			MODE_TURN: begin
				result.left_speed  = SPD_SPIN_LEFT;
				result.right_speed = SPD_SPIN_RIGHT;
			end
			MODE_SPIN: begin
				if (lines[CH_SPIN_STOP]) begin
					result.left_speed  = SPD_ZERO;
					result.right_speed = SPD_ZERO;
				end else begin
					result.left_speed  = SPD_SPIN_LEFT;
					result.right_speed = SPD_SPIN_RIGHT;
				end
			end
			MODE_IDLE: begin
				result.speed_update = 1'b0;
			end
			default: begin
				result.speed_update = 1'b0;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			hold_q  <= '0;
			round_q <= '0;
		end else begin
			mode_q  <= mode_d;
			hold_q  <= hold_d;
			round_q <= round_d;
		end
	end

`ifndef SYNTH
	// a blind spin hold only runs while spinning
	a_hold_in_spin: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q != '0 |-> mode_q == MODE_SPIN)
		else $error("hold count running outside spin mode");

	// round counter stays inside one averaging group
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		round_q < RC_W'(SAMPLES_PER_AVERAGE))
		else $error("round counter out of range");

	// a held round only counts the hold down
	a_hold_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && hold_q != '0 |=> hold_q == $past(hold_q) - HOLD_W'(1)
			&& round_q == $past(round_q))
		else $error("held round disturbed the round state");

	// no result while rounds are discarded
	a_no_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q != '0 |-> !produce && !ctl.add)
		else $error("result or sum update during hold");
`endif

endmodule

`default_nettype wire

>>> src/line_follow_steering.sv
// line_follow_steering: top level, six sensor lanes, steering stage, result register
// depends on lfs_pkg, lfs_lane, lfs_steer
//
//   channel   handshake                   payload     direction
//   sample    sample_valid/sample_ready   in_item_t   in
//   result    result_valid/result_ready   out_item_t  out
//   config    cfg_we                      cfg_wdata   in
//
// one request is taken per cycle while sample_ready is high; the lane add and
// compare and the mode update all finish in the cycle of acceptance
// a result sits in one output register and is offered in the cycle after its request
// sample_ready drops only while a result waits and result_ready is low
// reset clears sums, round counter, mode and hold count; registers get defaults
`timescale 1ns / 1ps
`default_nettype none

module line_follow_steering
	import lfs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  sample_valid,
	output logic                       sample_ready,
	input  wire in_item_t              sample,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output out_item_t                  result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [THR_W-1:0]    thr_q;
	logic [STOP_W-1:0]   stop_q;
	logic [HOLD_W-1:0]   hold_rounds_q;
	logic [CHANNELS-1:0] ignore_q;

	logic                   accept;
	logic [LIM_W-1:0]       limit;
	logic [SAMPLE_BITS-1:0] samples [CHANNELS];
	logic [CHANNELS-1:0]    hits;
	lane_ctl_t              ctl;
	logic                   produce;
	out_item_t              result_next;
	logic                   out_valid_q;
	out_item_t              out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= THR_RESET;
			stop_q        <= STOP_RESET;
			hold_rounds_q <= HOLD_RESET;
			ignore_q      <= IGNORE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_THRESHOLD:   thr_q         <= cfg_wdata[THR_W-1:0];
				REG_STOP_LINE_COUNT:  stop_q        <= cfg_wdata[STOP_W-1:0];
				REG_SPIN_HOLD_ROUNDS: hold_rounds_q <= cfg_wdata[HOLD_W-1:0];
				REG_IGNORED_CHANNELS: ignore_q      <= cfg_wdata[CHANNELS-1:0];
				default: ;
			endcase
		end
	end

	// line limit: sum over the group must reach (threshold + 1) times group size
	assign limit = (LIM_W'(thr_q) + LIM_W'(1)) * LIM_W'(SAMPLES_PER_AVERAGE);

	// handshake
	assign sample_ready = !out_valid_q || result_ready;
	assign accept       = sample_valid && sample_ready;

	assign samples[0] = sample.sample_ch0;
	assign samples[1] = sample.sample_ch1;
	assign samples[2] = sample.sample_ch2;
	assign samples[3] = sample.sample_ch3;
	assign samples[4] = sample.sample_ch4;
	assign samples[5] = sample.sample_ch5;

	// sensor lanes
	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		lfs_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sample (samples[g]),
			.hit    (hits[g])
		);
	end

	// merge and steering
	lfs_steer u_steer (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.start       (sample.start_command),
		.hits        (hits),
		.ignore_mask (ignore_q),
		.stop_count  (stop_q),
		.hold_rounds (hold_rounds_q),
		.limit       (limit),
		.ctl         (ctl),
		.produce     (produce),
		.result      (result_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (produce) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			out_q <= result_next;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire
